// File: rtl/odo_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the odometry block.
`timescale 1ns / 1ps
package odo_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int CW = 34;          // CORDIC datapath width
    localparam int DEN_W = 56;       // divisor width
    localparam int QUO_W = 57;       // quotient width
    localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_v;
        logic signed [CW-1:0] sin_v;
    } t_cordic_out;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } t_div_out;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/odo_if.sv
// Valid/ready channel interfaces for odometry samples and pose results.
`timescale 1ns / 1ps
interface odo_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [15:0]        imu_yaw;
    logic               reset_request;

    modport source(output valid, left_count, right_count, imu_yaw, reset_request,
                   input ready);
    modport sink(input valid, left_count, right_count, imu_yaw, reset_request,
                 output ready);
endinterface

interface odo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        yaw_out;

    modport source(output valid, pos_x, pos_y, yaw_out, input ready);
    modport sink(input valid, pos_x, pos_y, yaw_out, output ready);
endinterface

// File: rtl/odo_cordic.sv
// Iterative CORDIC sine/cosine unit, one rotation step per cycle.
`timescale 1ns / 1ps
module odo_cordic
    import odo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_angle,
    output t_cordic_out o_res
);

    localparam logic [4:0] LAST = 5'(CORDIC_STEPS - 1);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_flip;
    logic [4:0]           r_i;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    logic [31:0]          w_sum;
    logic [31:0]          w_fold;
    logic signed [CW-1:0] w_xs;
    logic signed [CW-1:0] w_ys;
    logic signed [CW-1:0] w_at;

    assign w_sum  = i_angle + 32'h40000000;
    assign w_fold = w_sum[31] ? (i_angle - 32'h80000000) : i_angle;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_at   = $signed({{(CW-32){1'b0}}, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_flip <= w_sum[31];
                r_x    <= $signed({{(CW-32){1'b0}}, CORDIC_GAIN_Q30});
                r_y    <= '0;
                r_z    <= $signed({{(CW-32){w_fold[31]}}, w_fold});
            end else if (r_busy) begin
                if (!r_z[CW-1]) begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_at;
                end else begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cos_v = r_flip ? -r_x : r_x;
    assign o_res.sin_v = r_flip ? -r_y : r_y;

endmodule

// File: rtl/odo_div.sv
// Serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module odo_div
    import odo_pkg::*;
#(
    parameter int DVD_W = 93
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DEN_W-1:0] i_divisor,
    output t_div_out         o_res
);

    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DEN_W-1:0] r_dsr;
    logic [DEN_W-1:0] r_rem;
    logic [QUO_W-1:0] r_q;

    logic [DEN_W:0]   w_sh;
    logic [DEN_W:0]   w_diff;
    logic             w_ge;

    assign w_sh   = {r_rem, r_dvd[DVD_W-1]};
    assign w_diff = w_sh - {1'b0, r_dsr};
    assign w_ge   = w_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
                r_dvd  <= i_dividend;
                r_dsr  <= i_divisor;
                r_rem  <= '0;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
                r_q   <= {r_q[QUO_W-2:0], w_ge};
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_q;

endmodule

// File: rtl/differential_drive_odometry.sv
// Differential-drive wheel odometry top level: sequencer, shared multiplier, state.
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        left_count, right_count, imu_yaw, reset_request
//   o_out    out  valid/ready        pos_x, pos_y, yaw_out
//   i_cfg    in   i_cfg_we           i_cfg_idx, i_cfg_data
//
// Straight move: one 30-step CORDIC pass and three multiplies.
// Arc move: two serial divides (radius, heading change), two CORDIC passes and
// five multiplies, all through the single shared units.
// One sample at a time; i_in.ready is high only when the sequencer is idle.
// A finished pose waits in the output register; a stalled o_out holds the sequencer.
// Synchronous active-low reset clears pose, heading, offset and stored counts.
`timescale 1ns / 1ps
module differential_drive_odometry
    import odo_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    odo_in_if.sink      i_in,
    odo_out_if.source   o_out
);

    localparam int SH = ANGLE_BITS + 13;
    localparam int DVD_W = 64 + SH;

    localparam logic [1:0] REG_DPT   = 2'd0;
    localparam logic [1:0] REG_TRACK = 2'd1;
    localparam logic [1:0] REG_RX    = 2'd2;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_PREP = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_MWB  = 7'b0001000,
        S_CORD = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    typedef enum logic [3:0] {
        OP_DIST, OP_NUM, OP_DEN, OP_ND, OP_DIVR, OP_DIVA,
        OP_CORD0, OP_CORD1, OP_MULX, OP_MULY
    } t_op;

    t_state r_state;
    t_op    r_op;

    logic [31:0]          r_dpt;
    logic [23:0]          r_track;
    logic signed [31:0]   r_rx;

    logic signed [31:0]   r_pos_x;
    logic signed [31:0]   r_pos_y;
    logic [15:0]          r_head;
    logic [15:0]          r_off;
    logic [31:0]          r_prev_l;
    logic [31:0]          r_prev_r;

    logic [31:0]          r_lc;
    logic [31:0]          r_rc;
    logic [15:0]          r_imu;
    logic                 r_rst;

    logic                 r_straight;
    logic signed [31:0]   r_dr;
    logic [32:0]          r_ms;
    logic [32:0]          r_md;
    logic                 r_rneg;
    logic                 r_dneg;
    logic [DEN_W-1:0]     r_num;
    logic [DEN_W-1:0]     r_den;
    logic [63:0]          r_nd;
    logic [ANGLE_BITS-1:0] r_a;
    logic signed [31:0]   r_k;
    logic signed [CW-1:0] r_c0;
    logic signed [CW-1:0] r_fx;
    logic signed [CW-1:0] r_fy;
    logic signed [67:0]   r_prod;

    logic                 r_cstart;
    logic [31:0]          r_cang;
    logic                 r_dstart;
    logic [DVD_W-1:0]     r_dvd;
    logic [DEN_W-1:0]     r_dsr;

    logic                 r_ovalid;
    logic signed [31:0]   r_ox;
    logic signed [31:0]   r_oy;
    logic [15:0]          r_oyaw;

    t_cordic_out          w_cord;
    t_div_out             w_div;

    logic [31:0]          w_dl;
    logic [31:0]          w_dr;
    logic signed [32:0]   w_dd;
    logic signed [32:0]   w_sl;
    logic [23:0]          w_t;
    logic signed [CW-1:0] w_ma;
    logic signed [CW-1:0] w_mb;
    logic signed [38:0]   w_acc;
    logic signed [CW:0]   w_dsx;
    logic signed [CW:0]   w_dcy;
    logic [QUO_W-1:0]     w_q;
    logic [ANGLE_BITS-1:0] w_araw;
    logic [31:0]          w_th;

    assign w_dl  = r_lc - r_prev_l;
    assign w_dr  = r_rc - r_prev_r;
    assign w_dd  = {w_dr[31], w_dr} - {w_dl[31], w_dl};
    assign w_sl  = {w_dr[31], w_dr} + {w_dl[31], w_dl};
    assign w_t   = (r_track == '0) ? 24'd1 : r_track;
    assign w_th  = {r_head, 16'h0000};
    assign w_q   = w_div.quot;
    assign w_araw = w_q[ANGLE_BITS-1:0];
    assign w_dsx = {w_cord.sin_v[CW-1], w_cord.sin_v} - {r_fy[CW-1], r_fy};
    assign w_dcy = {r_c0[CW-1], r_c0} - {w_cord.cos_v[CW-1], w_cord.cos_v};

    always_comb begin
        case (r_op)
            OP_DIST: begin
                w_ma = $signed({{(CW-32){r_dr[31]}}, r_dr});
                w_mb = $signed({{(CW-32){1'b0}}, r_dpt});
            end
            OP_NUM: begin
                w_ma = $signed({1'b0, r_ms});
                w_mb = $signed({{(CW-24){1'b0}}, w_t});
            end
            OP_DEN: begin
                w_ma = $signed({{(CW-32){1'b0}}, TWO_PI_Q29});
                w_mb = $signed({{(CW-24){1'b0}}, w_t});
            end
            OP_ND: begin
                w_ma = $signed({1'b0, r_md});
                w_mb = $signed({{(CW-32){1'b0}}, r_dpt});
            end
            OP_MULX: begin
                w_ma = $signed({{(CW-32){r_k[31]}}, r_k});
                w_mb = r_fx;
            end
            OP_MULY: begin
                w_ma = $signed({{(CW-32){r_k[31]}}, r_k});
                w_mb = r_fy;
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_comb begin
        if (r_op == OP_MULX) begin
            w_acc = $signed({{7{r_pos_x[31]}}, r_pos_x}) + $signed({r_prod[67], r_prod[67:30]});
        end else begin
            w_acc = $signed({{7{r_pos_y[31]}}, r_pos_y}) + $signed({r_prod[67], r_prod[67:30]});
        end
    end

    odo_cordic u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_cstart),
        .i_angle(r_cang),
        .o_res  (w_cord)
    );

    odo_div #(
        .DVD_W(DVD_W)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_dstart),
        .i_dividend(r_dvd),
        .i_divisor (r_dsr),
        .o_res     (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpt   <= 32'd281106;
            r_track <= 24'd19661;
            r_rx    <= 32'sd15729;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_DPT:   r_dpt   <= i_cfg_data;
                REG_TRACK: r_track <= i_cfg_data[23:0];
                REG_RX:    r_rx    <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_DIST;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_head   <= '0;
            r_off    <= '0;
            r_prev_l <= '0;
            r_prev_r <= '0;
            r_cstart <= 1'b0;
            r_dstart <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_cstart <= 1'b0;
            r_dstart <= 1'b0;
            if (o_out.ready && (r_state != S_FIN)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_lc    <= i_in.left_count;
                        r_rc    <= i_in.right_count;
                        r_imu   <= i_in.imu_yaw;
                        r_rst   <= i_in.reset_request;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_straight <= (w_dl == w_dr) || (r_dpt == '0);
                    r_dr     <= w_dr;
                    r_ms     <= w_sl[32] ? -w_sl : w_sl;
                    r_md     <= w_dd[32] ? -w_dd : w_dd;
                    r_rneg   <= w_sl[32] != w_dd[32];
                    r_dneg   <= w_dd[32];
                    r_prev_l <= r_lc;
                    r_prev_r <= r_rc;
                    r_op     <= ((w_dl == w_dr) || (r_dpt == '0)) ? OP_DIST : OP_NUM;
                    r_state  <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= w_ma * w_mb;
                    r_state <= S_MWB;
                end
                S_MWB: begin
                    case (r_op)
                        OP_DIST: begin
                            r_k      <= sat32({{12{r_prod[67]}}, r_prod[67:16]});
                            r_cang   <= w_th;
                            r_cstart <= 1'b1;
                            r_op     <= OP_CORD0;
                            r_state  <= S_CORD;
                        end
                        OP_NUM: begin
                            r_num   <= r_prod[DEN_W-1:0];
                            r_op    <= OP_DEN;
                            r_state <= S_MUL;
                        end
                        OP_DEN: begin
                            r_den   <= r_prod[DEN_W-1:0];
                            r_op    <= OP_ND;
                            r_state <= S_MUL;
                        end
                        OP_ND: begin
                            r_nd     <= r_prod[63:0];
                            r_dvd    <= {{(DVD_W-DEN_W){1'b0}}, r_num};
                            r_dsr    <= {{(DEN_W-34){1'b0}}, r_md, 1'b0};
                            r_dstart <= 1'b1;
                            r_op     <= OP_DIVR;
                            r_state  <= S_DIV;
                        end
                        OP_MULX: begin
                            r_pos_x <= sat32({{25{w_acc[38]}}, w_acc});
                            r_op    <= OP_MULY;
                            r_state <= S_MUL;
                        end
                        default: begin
                            r_pos_y <= sat32({{25{w_acc[38]}}, w_acc});
                            r_state <= S_FIN;
                        end
                    endcase
                end
                S_DIV: begin
                    if (w_div.done) begin
                        if (r_op == OP_DIVR) begin
                            if (r_rneg) begin
                                r_k <= (w_q > QUO_W'(64'h80000000)) ? 32'sh80000000
                                                                      : -w_q[31:0];
                            end else begin
                                r_k <= (w_q > QUO_W'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                                      : w_q[31:0];
                            end
                            r_dvd    <= {r_nd, {SH{1'b0}}};
                            r_dsr    <= r_den;
                            r_dstart <= 1'b1;
                            r_op     <= OP_DIVA;
                        end else begin
                            r_a      <= r_dneg ? -w_araw : w_araw;
                            r_cang   <= w_th;
                            r_cstart <= 1'b1;
                            r_op     <= OP_CORD0;
                            r_state  <= S_CORD;
                        end
                    end
                end
                S_CORD: begin
                    if (w_cord.done) begin
                        if (r_op == OP_CORD0) begin
                            r_c0 <= w_cord.cos_v;
                            r_fy <= w_cord.sin_v;
                            if (r_straight) begin
                                r_fx    <= w_cord.cos_v;
                                r_op    <= OP_MULX;
                                r_state <= S_MUL;
                            end else begin
                                r_cang   <= w_th + {r_a, {(32-ANGLE_BITS){1'b0}}};
                                r_cstart <= 1'b1;
                                r_op     <= OP_CORD1;
                            end
                        end else begin
                            r_fx    <= w_dsx[CW-1:0];
                            r_fy    <= w_dcy[CW-1:0];
                            r_op    <= OP_MULX;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_FIN: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_head   <= r_imu - r_off;
                        r_oyaw   <= r_imu - r_off;
                        r_ovalid <= 1'b1;
                        if (r_rst) begin
                            r_pos_x <= r_rx;
                            r_pos_y <= '0;
                            r_off   <= r_imu;
                            r_ox    <= r_rx;
                            r_oy    <= '0;
                        end else begin
                            r_ox <= r_pos_x;
                            r_oy <= r_pos_y;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_ovalid;
    assign o_out.pos_x   = r_ox;
    assign o_out.pos_y   = r_oy;
    assign o_out.yaw_out = r_oyaw;

    a_cord_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cord.done |-> (r_state == S_CORD))
        else $error("CORDIC finished outside its wait state");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_md != '0) && !r_straight))
        else $error("divide entered with zero wheel difference");

    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIN) && (!r_ovalid || o_out.ready)) |=> r_ovalid)
        else $error("finished pose not presented");

endmodule

// File: verif/differential_drive_odometry_tb.sv
// Self-checking testbench for differential_drive_odometry: directed table plus random tracks.
`timescale 1ns / 1ps
module differential_drive_odometry_tb;
    import odo_pkg::*;

    typedef enum logic [1:0] {
        REG_DIST_PER_TICK = 2'd0,
        REG_TRACK_WIDTH   = 2'd1,
        REG_RESET_X       = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [15:0]        yaw;
    } pose_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] left;
        logic [31:0] right;
        logic [15:0] imu;
        logic        rst_req;
        logic        typed;
        pose_t       pose;
    } sample_row_t;

    localparam int RANDOM_PER_PHASE = 306;
    localparam int PHASES = 5;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int N_ROWS = 18;

    localparam logic [31:0] ATAN_TAB [30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    localparam sample_row_t DIR_TAB [N_ROWS] = '{
        '{3'd0, 32'd0, 32'd0, 16'h1234, 1'b1, 1'b1, '{32'sd15729, 32'sd0, 16'h1234}},
        '{3'd0, 32'd0, 32'd0, 16'h1234, 1'b0, 1'b1, '{32'sd15729, 32'sd0, 16'h0000}},
        '{3'd0, 32'd100, 32'd100, 16'h2000, 1'b0, 1'b0, '0},
        '{3'd0, 32'd100, 32'd600, 16'h3000, 1'b0, 1'b0, '0},
        '{3'd0, 32'd600, 32'd700, 16'h5000, 1'b0, 1'b0, '0},
        '{3'd0, 32'd300, 32'd400, 16'h9000, 1'b0, 1'b0, '0},
        '{3'd0, 32'd500, 32'd200, 16'hC000, 1'b0, 1'b0, '0},
        '{3'd0, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
        '{3'd0, 32'h80000000, 32'h7FFFFFFF, 16'h0000, 1'b0, 1'b0, '0},
        '{3'd0, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 1'b0, 1'b0, '0},
        '{3'd0, 32'hFFFFFFFF, 32'h00000000, 16'h7FFF, 1'b0, 1'b0, '0},
        '{3'd0, 32'hFFFFFFFF, 32'h00000000, 16'hFFFF, 1'b1, 1'b0, '0},
        '{3'd1, 32'h00001000, 32'h00500000, 16'h4444, 1'b0, 1'b0, '0},
        '{3'd1, 32'h00001000, 32'h00500000, 16'h1111, 1'b1, 1'b0, '0},
        '{3'd2, 32'h00001005, 32'h00500000, 16'h0100, 1'b0, 1'b0, '0},
        '{3'd2, 32'h40001005, 32'h40500000, 16'h0200, 1'b0, 1'b0, '0},
        '{3'd2, 32'h80000000, 32'h7FFFFFFF, 16'hABCD, 1'b0, 1'b0, '0},
        '{3'd3, 32'h00000010, 32'h00001010, 16'h0010, 1'b0, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [31:0] i_cfg_data;

    odo_in_if in_ch();
    odo_out_if out_ch();

    differential_drive_odometry uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in(in_ch.sink),
        .o_out(out_ch.source)
    );

    // model state
    logic [31:0] m_dist_per_tick, m_track, m_reset_x;
    longint m_px, m_py;
    logic [15:0] m_heading, m_offset;
    logic [31:0] m_prev_l, m_prev_r;

    pose_t pose_q[$];
    int errors;
    longint cycles;
    int stall_cnt;
    bit stall_mode;
    int burst_left;
    logic [31:0] last_l, last_r;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.left_count = '0;
        in_ch.right_count = '0;
        in_ch.imu_yaw = '0;
        in_ch.reset_request = 1'b0;
        out_ch.ready = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("differential_drive_odometry regression: fail");
            $finish;
        end
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
        logic [31:0] a;
        bit flip;
        longint x, y, z, xs, ys;
        a = ang;
        flip = 1'b0;
        x = 64'sd652032874;
        y = 0;
        if (((a + 32'h40000000) & 32'h80000000) != 0) begin
            a = a - 32'h80000000;
            flip = 1'b1;
        end
        z = longint'($signed(a));
        for (int i = 0; i < 30; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - longint'({32'd0, ATAN_TAB[i]});
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + longint'({32'd0, ATAN_TAB[i]});
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    task automatic advance_pose(input sample_row_t smp, output pose_t res);
        longint dl_t, dr_t, dpt, dl, dr, d, c0, s0, c1, s1, dd, sl, r;
        logic [63:0] t, mag_d, mag_s, q, den, rem, a;
        logic [31:0] th;
        dl_t = longint'($signed(smp.left - m_prev_l));
        dr_t = longint'($signed(smp.right - m_prev_r));
        dpt = longint'({32'd0, m_dist_per_tick});
        dl = dl_t * dpt;
        dr = dr_t * dpt;
        th = {m_heading, 16'd0};
        if (dl == dr) begin
            d = clamp32(dr >>> 16);
            rotate_unit(th, c0, s0);
            m_px = clamp32(m_px + ((d * c0) >>> 30));
            m_py = clamp32(m_py + ((d * s0) >>> 30));
        end else begin
            dd = dr_t - dl_t;
            sl = dl_t + dr_t;
            t = (m_track == 0) ? 64'd1 : {32'd0, m_track};
            mag_d = (dd < 0) ? -dd : dd;
            mag_s = (sl < 0) ? -sl : sl;
            q = (mag_s * t) / (2 * mag_d);
            if ((sl < 0) != (dd < 0))
                r = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
            else
                r = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
            den = {32'd0, TWO_PI_Q29} * t;
            rem = (mag_d * {32'd0, m_dist_per_tick}) % den;
            a = 0;
            for (int i = 0; i < 29; i++) begin
                rem = rem << 1;
                a = a << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    a[0] = 1'b1;
                end
                a = a & 64'hFFFF;
            end
            if (dd < 0) a = (64'd0 - a) & 64'hFFFF;
            rotate_unit(th, c0, s0);
            rotate_unit(th + {a[15:0], 16'd0}, c1, s1);
            m_px = clamp32(m_px + ((r * (s1 - s0)) >>> 30));
            m_py = clamp32(m_py + ((r * (c0 - c1)) >>> 30));
        end
        m_heading = smp.imu - m_offset;
        if (smp.rst_req) begin
            m_px = longint'($signed(m_reset_x));
            m_py = 0;
            m_offset = smp.imu;
        end
        m_prev_l = smp.left;
        m_prev_r = smp.right;
        res.x = m_px[31:0];
        res.y = m_py[31:0];
        res.yaw = m_heading;
    endtask

    // receiver: check and stall
    always @(posedge i_clk) begin
        pose_t exp_pose;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected pose x=%0d y=%0d yaw=%h", $time,
                         out_ch.pos_x, out_ch.pos_y, out_ch.yaw_out);
                errors++;
            end else begin
                exp_pose = pose_q.pop_front();
                if (out_ch.pos_x !== exp_pose.x) begin
                    $display("%0t: pos_x expected %0d actual %0d", $time,
                             exp_pose.x, out_ch.pos_x);
                    errors++;
                end
                if (out_ch.pos_y !== exp_pose.y) begin
                    $display("%0t: pos_y expected %0d actual %0d", $time,
                             exp_pose.y, out_ch.pos_y);
                    errors++;
                end
                if (out_ch.yaw_out !== exp_pose.yaw) begin
                    $display("%0t: yaw_out expected %h actual %h", $time,
                             exp_pose.yaw, out_ch.yaw_out);
                    errors++;
                end
            end
        end
        stall_cnt++;
        if (stall_cnt >= 300) begin
            stall_cnt = 0;
            stall_mode = ~stall_mode;
        end
        out_ch.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            REG_DIST_PER_TICK: m_dist_per_tick = val;
            REG_TRACK_WIDTH:   m_track = {8'd0, val[23:0]};
            default:           m_reset_x = val;
        endcase
    endtask

    task automatic send_sample(input sample_row_t smp, input bit allow_gap);
        pose_t res;
        if (allow_gap && burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.left_count <= smp.left;
        in_ch.right_count <= smp.right;
        in_ch.imu_yaw <= smp.imu;
        in_ch.reset_request <= smp.rst_req;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        advance_pose(smp, res);
        if (smp.typed) pose_q.push_back(smp.pose);
        else pose_q.push_back(res);
        last_l = smp.left;
        last_r = smp.right;
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    initial begin
        sample_row_t smp;
        int kind;
        bit gaps;
        logic [31:0] step;
        errors = 0;
        cycles = 0;
        stall_cnt = 0;
        stall_mode = 1'b0;
        burst_left = 0;
        m_dist_per_tick = 32'd281106;
        m_track = 32'd19661;
        m_reset_x = 32'd15729;
        m_px = 0;
        m_py = 0;
        m_heading = '0;
        m_offset = '0;
        m_prev_l = '0;
        m_prev_r = '0;
        last_l = '0;
        last_r = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                1: begin
                    write_reg(REG_DIST_PER_TICK, 32'd0);
                    write_reg(REG_TRACK_WIDTH, 32'd1);
                    write_reg(REG_RESET_X, 32'h80000000);
                end
                2: begin
                    write_reg(REG_DIST_PER_TICK, 32'hFFFFFFFF);
                    write_reg(REG_TRACK_WIDTH, 32'd0);
                    write_reg(REG_RESET_X, 32'h7FFFFFFF);
                end
                3: begin
                    write_reg(REG_DIST_PER_TICK, 32'd1);
                    write_reg(REG_TRACK_WIDTH, 32'hFFFFFF);
                    write_reg(REG_RESET_X, 32'd0);
                end
                4: begin
                    write_reg(REG_DIST_PER_TICK, $urandom_range(1000, 5000000));
                    write_reg(REG_TRACK_WIDTH, $urandom_range(1000, 200000));
                    write_reg(REG_RESET_X, $urandom);
                end
                default: ;
            endcase
            if (ph > 0) i_cfg_we <= 1'b0;
            for (int k = 0; k < N_ROWS; k++)
                if (DIR_TAB[k].phase == ph) send_sample(DIR_TAB[k], 1'b1);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (n % 100 == 0) gaps = ($urandom_range(0, 2) != 0);
                smp = '0;
                kind = $urandom_range(0, 19);
                step = $urandom_range(0, 2000) - 1000;
                if (kind < 3) begin
                    smp.left = $urandom;
                    smp.right = $urandom;
                end else if (kind < 7) begin
                    smp.left = last_l + step;
                    smp.right = last_r + step;
                end else begin
                    smp.left = last_l + step;
                    smp.right = last_r + ($urandom_range(0, 2000) - 1000);
                end
                smp.imu = $urandom;
                smp.rst_req = ($urandom_range(0, 19) == 0);
                send_sample(smp, gaps);
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("differential_drive_odometry regression: pass");
        end else begin
            $display("differential_drive_odometry regression: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/odo_pkg.sv
rtl/odo_if.sv
rtl/odo_cordic.sv
rtl/odo_div.sv
rtl/differential_drive_odometry.sv
verif/differential_drive_odometry_tb.sv
